// ===== hw/rtl/structural_pseudo_class_matcher_macros.svh =====
// Assertion macros shared by the matcher's RTL.
// Both expect signals named clk and rst_n in the module that uses them.
`ifndef STRUCTURAL_PSEUDO_CLASS_MATCHER_MACROS_SVH
`define STRUCTURAL_PSEUDO_CLASS_MATCHER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SPCM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spcm same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define SPCM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spcm next-cycle check failed");

`endif

// ===== hw/rtl/spcm_pkg.sv =====
`default_nettype none

package spcm_pkg;

    localparam int KIND_W           = 2;
    localparam int TAG_W            = 16;
    localparam int MODE_W           = 4;
    localparam int COEF_W           = 12;
    localparam int CFG_IDX_W        = 2;
    localparam int CFG_DATA_W       = 12;
    localparam int CNT_CAP          = 2047;
    localparam int MAX_SIBLINGS_DEF = 1024;
    // positions reach CNT_CAP + 1, differences pos - b span -2046 .. 4096
    localparam int POS_W            = 12;
    localparam int DIFF_W           = 14;
    localparam int MAG_W            = 13;

    localparam logic [KIND_W-1:0] KIND_ENTRY     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_NO_PARENT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EMPTY     = 2'd2;

    localparam logic [MODE_W-1:0] MODE_EMPTY            = 4'd0;
    localparam logic [MODE_W-1:0] MODE_FIRST            = 4'd1;
    localparam logic [MODE_W-1:0] MODE_FIRST_OF_TYPE    = 4'd2;
    localparam logic [MODE_W-1:0] MODE_LAST             = 4'd3;
    localparam logic [MODE_W-1:0] MODE_LAST_OF_TYPE     = 4'd4;
    localparam logic [MODE_W-1:0] MODE_NTH              = 4'd5;
    localparam logic [MODE_W-1:0] MODE_NTH_LAST         = 4'd6;
    localparam logic [MODE_W-1:0] MODE_NTH_LAST_OF_TYPE = 4'd7;
    localparam logic [MODE_W-1:0] MODE_NTH_OF_TYPE      = 4'd8;
    localparam logic [MODE_W-1:0] MODE_ONLY             = 4'd9;
    localparam logic [MODE_W-1:0] MODE_ONLY_OF_TYPE     = 4'd10;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_A   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_B = 2'd2;

    typedef struct packed {
        logic take;
        logic div_start;
        logic push;
    } spcm_cmd_t;

    typedef struct packed {
        logic ends_list;
        logic needs_div;
        logic div_done;
        logic out_full;
    } spcm_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/spcm_in_if.sv =====
`default_nettype none

interface spcm_in_if
    import spcm_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [TAG_W-1:0]  tag_id;
    logic [TAG_W-1:0]  target_tag;
    logic              visible;
    logic              is_target;
    logic              last_item;

    modport source (output valid, kind, tag_id, target_tag, visible, is_target, last_item,
                    input ready);
    modport sink   (input valid, kind, tag_id, target_tag, visible, is_target, last_item,
                    output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/spcm_out_if.sv =====
`default_nettype none

interface spcm_out_if;
    logic valid;
    logic ready;
    logic matched;

    modport source (output valid, matched, input ready);
    modport sink   (input valid, matched, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/spcm_cfg_if.sv =====
`default_nettype none

interface spcm_cfg_if
    import spcm_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/spcm_divider.sv =====
`default_nettype none
`include "structural_pseudo_class_matcher_macros.svh"

// Restoring divider, one quotient bit per cycle; only the remainder is kept.
module spcm_divider
    import spcm_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [MAG_W-1:0]  dividend,
    input  wire logic [COEF_W-1:0] divisor,
    output logic                   done,
    output logic                   rem_zero
);

    localparam int STEP_W = $clog2(MAG_W);

    logic [MAG_W-1:0]  quo_reg;
    logic [MAG_W-1:0]  rem_reg;
    logic [COEF_W-1:0] den_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [MAG_W-1:0]  rem_sh;

    // shift in the next dividend bit; remainder stays below the divisor
    assign rem_sh = {rem_reg[MAG_W-2:0], quo_reg[MAG_W-1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(MAG_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[MAG_W-2:0], 1'b0};
            if (rem_sh >= MAG_W'(den_reg))
                rem_reg <= rem_sh - MAG_W'(den_reg);
            else
                rem_reg <= rem_sh;
        end
    end

    assign done     = done_reg;
    assign rem_zero = (rem_reg == '0);

    `SPCM_ASSERT_NEXT(a_start_clears_done, start, busy_reg && !done_reg)
    `SPCM_ASSERT_NOW(a_busy_not_done, busy_reg, !done_reg)
    `SPCM_ASSERT_NOW(a_rem_below_den, done_reg && (den_reg != '0), rem_reg < MAG_W'(den_reg))

endmodule

`default_nettype wire

// ===== hw/rtl/spcm_datapath.sv =====
`default_nettype none

module spcm_datapath
    import spcm_pkg::*;
#(
    parameter int MAX_SIBLINGS = MAX_SIBLINGS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [KIND_W-1:0]     kind,
    input  wire logic [TAG_W-1:0]      tag_id,
    input  wire logic [TAG_W-1:0]      target_tag,
    input  wire logic                  visible,
    input  wire logic                  is_target,
    input  wire logic                  last_item,
    input  wire logic                  cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  out_ready,
    output logic                       out_valid,
    output logic                       out_matched,
    input  wire spcm_cmd_t             cmd,
    output spcm_status_t               st
);

    localparam int CNT_LIM = (MAX_SIBLINGS < CNT_CAP) ? MAX_SIBLINGS : CNT_CAP;
    localparam int CNT_W   = $clog2(CNT_LIM + 1);

    logic [MODE_W-1:0]        mode_reg;
    logic signed [COEF_W-1:0] coef_a_reg;
    logic signed [COEF_W-1:0] offset_b_reg;

    logic             target_seen_reg, target_seen_next;
    logic             first_was_target_reg, first_was_target_next;
    logic             any_visible_reg, any_visible_next;
    logic [CNT_W-1:0] visible_before_reg, visible_before_next;
    logic [CNT_W-1:0] visible_after_reg, visible_after_next;
    logic [CNT_W-1:0] same_tag_before_reg, same_tag_before_next;
    logic [CNT_W-1:0] same_tag_after_reg, same_tag_after_next;
    logic [CNT_W-1:0] item_count_reg, item_count_next;

    // list state after this item, and the view that evaluation sees
    logic             this_is_target;
    logic             upd_ts, upd_fwt, upd_any;
    logic [CNT_W-1:0] upd_vb, upd_va, upd_sb, upd_sa, upd_ic;
    logic             ev_ts, ev_fwt, ev_any, ev_last_tgt;
    logic [CNT_W-1:0] ev_vb, ev_va, ev_sb, ev_sa;
    logic [CNT_W-1:0] pos_sel;
    logic             simple_next;
    logic [POS_W-1:0] pos_next;

    logic             simple_reg;
    logic             use_div_reg;
    logic [POS_W-1:0] pos_reg;
    logic             out_valid_reg;
    logic             out_matched_reg;

    logic signed [DIFF_W-1:0] diff;
    logic [MAG_W-1:0]         diff_mag;
    logic [COEF_W-1:0]        coef_mag;
    logic                     div_done;
    logic                     rem_zero;
    logic                     nth_ok;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        return (c < CNT_W'(CNT_LIM)) ? c + CNT_W'(1) : c;
    endfunction

    always_comb
    begin
        this_is_target = is_target && !target_seen_reg;
        upd_ts  = target_seen_reg || this_is_target;
        upd_fwt = (item_count_reg == '0) ? this_is_target : first_was_target_reg;
        upd_any = any_visible_reg || visible;
        upd_vb  = visible_before_reg;
        upd_va  = visible_after_reg;
        upd_sb  = same_tag_before_reg;
        upd_sa  = same_tag_after_reg;
        upd_ic  = sat_inc(item_count_reg);
        if (!this_is_target && visible)
        begin
            if (target_seen_reg)
            begin
                upd_va = sat_inc(visible_after_reg);
                if (tag_id == target_tag)
                    upd_sa = sat_inc(same_tag_after_reg);
            end
            else
            begin
                upd_vb = sat_inc(visible_before_reg);
                if (tag_id == target_tag)
                    upd_sb = sat_inc(same_tag_before_reg);
            end
        end
    end

    // an empty list is evaluated on cleared state
    always_comb
    begin
        if (kind == KIND_EMPTY)
        begin
            ev_ts       = 1'b0;
            ev_fwt      = 1'b0;
            ev_any      = 1'b0;
            ev_last_tgt = 1'b0;
            ev_vb       = '0;
            ev_va       = '0;
            ev_sb       = '0;
            ev_sa       = '0;
        end
        else
        begin
            ev_ts       = upd_ts;
            ev_fwt      = upd_fwt;
            ev_any      = upd_any;
            ev_last_tgt = this_is_target;
            ev_vb       = upd_vb;
            ev_va       = upd_va;
            ev_sb       = upd_sb;
            ev_sa       = upd_sa;
        end
    end

    always_comb
    begin
        simple_next = 1'b0;
        pos_sel     = ev_vb;
        case (mode_reg)
            MODE_EMPTY:            simple_next = !ev_any;
            MODE_FIRST:            simple_next = ev_fwt;
            MODE_FIRST_OF_TYPE:    simple_next = ev_ts && (ev_sb == '0);
            MODE_LAST:             simple_next = ev_last_tgt;
            MODE_LAST_OF_TYPE:     simple_next = ev_ts && (ev_sa == '0);
            MODE_NTH:              pos_sel = ev_vb;
            MODE_NTH_LAST:         pos_sel = ev_ts ? ev_va : ev_vb;
            MODE_NTH_LAST_OF_TYPE: pos_sel = ev_ts ? ev_sa : ev_sb;
            MODE_NTH_OF_TYPE:      pos_sel = ev_sb;
            MODE_ONLY:             simple_next = (ev_vb == '0) && (ev_va == '0);
            MODE_ONLY_OF_TYPE:     simple_next = (ev_sb == '0) && (ev_sa == '0);
            default:               simple_next = 1'b0;
        endcase
        if (kind == KIND_NO_PARENT)
            simple_next = 1'b0;
        pos_next = POS_W'(pos_sel) + POS_W'(1);
    end

    always_comb
    begin
        st.ends_list = (kind == KIND_NO_PARENT) || (kind == KIND_EMPTY)
                       || ((kind == KIND_ENTRY) && last_item);
        st.needs_div = st.ends_list && (kind != KIND_NO_PARENT)
                       && (mode_reg inside {[MODE_NTH:MODE_NTH_OF_TYPE]});
        st.div_done  = div_done;
        st.out_full  = out_valid_reg && !out_ready;
    end

    always_comb
    begin
        target_seen_next      = target_seen_reg;
        first_was_target_next = first_was_target_reg;
        any_visible_next      = any_visible_reg;
        visible_before_next   = visible_before_reg;
        visible_after_next    = visible_after_reg;
        same_tag_before_next  = same_tag_before_reg;
        same_tag_after_next   = same_tag_after_reg;
        item_count_next       = item_count_reg;
        if (cmd.take)
        begin
            if (st.ends_list)
            begin
                target_seen_next      = 1'b0;
                first_was_target_next = 1'b0;
                any_visible_next      = 1'b0;
                visible_before_next   = '0;
                visible_after_next    = '0;
                same_tag_before_next  = '0;
                same_tag_after_next   = '0;
                item_count_next       = '0;
            end
            else if (kind == KIND_ENTRY)
            begin
                target_seen_next      = upd_ts;
                first_was_target_next = upd_fwt;
                any_visible_next      = upd_any;
                visible_before_next   = upd_vb;
                visible_after_next    = upd_va;
                same_tag_before_next  = upd_sb;
                same_tag_after_next   = upd_sa;
                item_count_next       = upd_ic;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_seen_reg      <= 1'b0;
            first_was_target_reg <= 1'b0;
            any_visible_reg      <= 1'b0;
            visible_before_reg   <= '0;
            visible_after_reg    <= '0;
            same_tag_before_reg  <= '0;
            same_tag_after_reg   <= '0;
            item_count_reg       <= '0;
        end
        else
        begin
            target_seen_reg      <= target_seen_next;
            first_was_target_reg <= first_was_target_next;
            any_visible_reg      <= any_visible_next;
            visible_before_reg   <= visible_before_next;
            visible_after_reg    <= visible_after_next;
            same_tag_before_reg  <= same_tag_before_next;
            same_tag_after_reg   <= same_tag_after_next;
            item_count_reg       <= item_count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_EMPTY;
            coef_a_reg   <= '0;
            offset_b_reg <= COEF_W'(1);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_MODE:     mode_reg     <= cfg_data[MODE_W-1:0];
                CFG_COEF_A:   coef_a_reg   <= cfg_data[COEF_W-1:0];
                CFG_OFFSET_B: offset_b_reg <= cfg_data[COEF_W-1:0];
                default:      ;
            endcase
        end
    end

    // evaluation snapshot, taken on the item that closes a list
    always_ff @(posedge clk)
    begin
        if (cmd.take && st.ends_list)
        begin
            simple_reg  <= simple_next;
            use_div_reg <= st.needs_div;
            pos_reg     <= pos_next;
        end
    end

    assign diff     = $signed({2'b00, pos_reg}) - DIFF_W'(offset_b_reg);
    assign diff_mag = diff[DIFF_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
    assign coef_mag = coef_a_reg[COEF_W-1] ? COEF_W'(-coef_a_reg) : COEF_W'(coef_a_reg);

    spcm_divider u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (diff_mag),
        .divisor  (coef_mag),
        .done     (div_done),
        .rem_zero (rem_zero)
    );

    // a*n + b hits pos: exact quotient that is not negative
    always_comb
    begin
        if (coef_a_reg == '0)
            nth_ok = (diff == '0);
        else
            nth_ok = rem_zero
                     && ((diff == '0) || (diff[DIFF_W-1] == coef_a_reg[COEF_W-1]));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.push)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
            out_matched_reg <= use_div_reg ? nth_ok : simple_reg;
    end

    assign out_valid   = out_valid_reg;
    assign out_matched = out_matched_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/spcm_ctrl.sv =====
`default_nettype none
`include "structural_pseudo_class_matcher_macros.svh"

module spcm_ctrl
    import spcm_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         sib_valid,
    output logic              sib_ready,
    input  wire spcm_status_t st,
    output spcm_cmd_t         cmd
);

    localparam logic [1:0] S_RUN   = 2'd0;
    localparam logic [1:0] S_START = 2'd1;
    localparam logic [1:0] S_DIV   = 2'd2;
    localparam logic [1:0] S_PUSH  = 2'd3;

    logic [1:0] state_reg, state_next;

    always_comb
    begin
        sib_ready  = (state_reg == S_RUN);
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_RUN:
            begin
                cmd.take = sib_valid;
                if (sib_valid && st.ends_list)
                    state_next = st.needs_div ? S_START : S_PUSH;
            end
            S_START:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                if (st.div_done)
                    state_next = S_PUSH;
            end
            S_PUSH:
            begin
                if (!st.out_full)
                begin
                    cmd.push   = 1'b1;
                    state_next = S_RUN;
                end
            end
            default: state_next = S_RUN;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_RUN;
        else
            state_reg <= state_next;
    end

    `SPCM_ASSERT_NEXT(a_list_end_stalls, cmd.take && st.ends_list, state_reg != S_RUN)
    `SPCM_ASSERT_NEXT(a_div_done_pushes, (state_reg == S_DIV) && st.div_done, state_reg == S_PUSH)
    `SPCM_ASSERT_NOW(a_push_has_room, cmd.push, !st.out_full && (state_reg == S_PUSH))

endmodule

`default_nettype wire

// ===== hw/rtl/structural_pseudo_class_matcher.sv =====
// Channel | Dir | Interface     | Payload
// --------+-----+---------------+--------------------------------------------------
// sib     | in  | spcm_in_if    | kind, tag_id, target_tag, visible, is_target,
//         |     |               | last_item (one sibling per transaction)
// res     | out | spcm_out_if   | matched (one transaction per closed list)
// cfg     | in  | spcm_cfg_if   | index (0 mode, 1 coef_a, 2 offset_b), data
//
// Counters update as each sibling transaction is accepted. The transaction that
// closes a list holds sib.ready low until its result is pushed in the plain modes,
// and in the nth modes, no-parent aside, until the 13-step restoring divider has run.
// A result still waiting on res stretches that hold until res drains; siblings up
// to the next closing transaction stream on meanwhile. rst_n clears list state and
// control asynchronously; mode 0, coef_a 0, offset_b 1. cfg is always ready; write idle.
`default_nettype none

module structural_pseudo_class_matcher
    import spcm_pkg::*;
#(
    parameter int MAX_SIBLINGS = MAX_SIBLINGS_DEF
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    spcm_in_if.sink    sib,
    spcm_out_if.source res,
    spcm_cfg_if.sink   cfg
);

    spcm_cmd_t    cmd;
    spcm_status_t st;

    // register writes are never back-pressured
    assign cfg.ready = 1'b1;

    // sequencer: accept siblings, launch the divider, hand the result over
    spcm_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .sib_valid (sib.valid),
        .sib_ready (sib.ready),
        .st        (st),
        .cmd       (cmd)
    );

    // counters, snapshot, an+b test and the output register
    spcm_datapath #(
        .MAX_SIBLINGS (MAX_SIBLINGS)
    ) u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .kind        (sib.kind),
        .tag_id      (sib.tag_id),
        .target_tag  (sib.target_tag),
        .visible     (sib.visible),
        .is_target   (sib.is_target),
        .last_item   (sib.last_item),
        .cfg_valid   (cfg.valid),
        .cfg_index   (cfg.index),
        .cfg_data    (cfg.data),
        .out_ready   (res.ready),
        .out_valid   (res.valid),
        .out_matched (res.matched),
        .cmd         (cmd),
        .st          (st)
    );

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import spcm_pkg::*;

    // Small sibling cap so that long lists drive every counter into saturation.
    localparam int SIB_CAP      = 24;
    localparam int CNT_LIMIT    = (SIB_CAP < 2047) ? SIB_CAP : 2047;
    // Closing transaction of an nth list holds the block while the divider runs; allow margin.
    localparam int DRAIN_CYCLES = 24;
    localparam int RAND_ITEMS   = 1350;
    localparam int PLAN_LEN     = 46;

    // Codes the package leaves unnamed.
    localparam logic [KIND_W-1:0]    KIND_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED  = 2'd3;
    localparam logic [MODE_W-1:0]    MODE_BOGUS  = 4'd15;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [TAG_W-1:0]  tag_id;
        logic [TAG_W-1:0]  target_tag;
        logic              visible;
        logic              is_target;
        logic              last_item;
    } sib_t;

    typedef enum logic [1:0] {ROW_ITEM, ROW_CFG} row_act_t;
    typedef enum logic [1:0] {WANT_ZERO, WANT_ONE, WANT_CALC} want_t;

    typedef struct packed {
        row_act_t              act;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        sib_t                  item;
        want_t                 want;
    } row_t;

    localparam sib_t NO_SIB = '0;

    logic clk;
    logic rst_n;

    spcm_in_if  sib_if ();
    spcm_out_if res_if ();
    spcm_cfg_if cfg_if ();

    structural_pseudo_class_matcher #(
        .MAX_SIBLINGS (SIB_CAP)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .sib   (sib_if),
        .res   (res_if),
        .cfg   (cfg_if)
    );

    // Directed opening: reset defaults, field extremes, every pseudo-class and the
    // corner cases (no parent, empty list, unknown kind, unknown mode, target never
    // marked, repeated target, aborted list). Typed results are the obvious ones;
    // the rest go through the predictor.
    row_t plan [0:PLAN_LEN-1] = '{
        '{ROW_ITEM, CFG_MODE, 12'h000, '{KIND_EMPTY, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0},
          WANT_ONE},
        '{ROW_ITEM, CFG_MODE, 12'h000, '{KIND_NO_PARENT, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b1},
          WANT_ZERO},
        '{ROW_ITEM, CFG_MODE, 12'h000, '{KIND_UNUSED, 16'hFFFF, 16'h0000, 1'b1, 1'b1, 1'b1},
          WANT_CALC},
        '{ROW_ITEM, CFG_MODE, 12'h000, '{KIND_ENTRY, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 1'b1},
          WANT_ONE},
        '{ROW_ITEM, CFG_MODE, 12'h000, '{KIND_ENTRY, 16'h0000, 16'h0000, 1'b1, 1'b0, 1'b1},
          WANT_ZERO},
        '{ROW_CFG, CFG_MODE, 12'(MODE_FIRST), NO_SIB, WANT_CALC},
        '{ROW_ITEM, CFG_MODE, 12'h000, '{KIND_ENTRY, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b0},
          WANT_CALC},
        '{ROW_ITEM, CFG_MODE, 12'h000, '{KIND_ENTRY, 16'h0000, 16'hFFFF, 1'b1, 1'b0, 1'b1},
          WANT_ONE},
        '{ROW_CFG, CFG_MODE, 12'(MODE_LAST_OF_TYPE), NO_SIB, WANT_CALC},
        '{ROW_ITEM, CFG_MODE, 12'h000, '{KIND_ENTRY, 16'h1234, 16'h1234, 1'b1, 1'b0, 1'b1},
          WANT_ZERO},
        '{ROW_ITEM, CFG_MODE, 12'h000, '{KIND_ENTRY, 16'h1234, 16'h1234, 1'b1, 1'b1, 1'b0},
          WANT_CALC},
        '{ROW_ITEM, CFG_MODE, 12'h000, '{KIND_ENTRY, 16'h1234, 16'h1234, 1'b1, 1'b1, 1'b1},
          WANT_ZERO},
        '{ROW_CFG, CFG_MODE, 12'(MODE_NTH), NO_SIB, WANT_CALC},
        '{ROW_CFG, CFG_COEF_A, 12'hC00, NO_SIB, WANT_CALC},
        '{ROW_CFG, CFG_OFFSET_B, 12'h400, NO_SIB, WANT_CALC},
        '{ROW_ITEM, CFG_MODE, 12'h000, '{KIND_ENTRY, 16'h00FF, 16'h00FF, 1'b1, 1'b1, 1'b1},
          WANT_CALC},
        '{ROW_ITEM, CFG_MODE, 12'h000, '{KIND_EMPTY, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0},
          WANT_CALC},
        '{ROW_CFG, CFG_MODE, 12'(MODE_NTH_LAST_OF_TYPE), NO_SIB, WANT_CALC},
        '{ROW_CFG, CFG_COEF_A, 12'h400, NO_SIB, WANT_CALC},
        '{ROW_CFG, CFG_OFFSET_B, 12'hC00, NO_SIB, WANT_CALC},
        '{ROW_ITEM, CFG_MODE, 12'h000, '{KIND_ENTRY, 16'h00AA, 16'h00AA, 1'b1, 1'b0, 1'b0},
          WANT_CALC},
        '{ROW_ITEM, CFG_MODE, 12'h000, '{KIND_ENTRY, 16'h00AA, 16'h00AA, 1'b0, 1'b1, 1'b0},
          WANT_CALC},
        '{ROW_ITEM, CFG_MODE, 12'h000, '{KIND_ENTRY, 16'h00AA, 16'h00AA, 1'b1, 1'b0, 1'b1},
          WANT_CALC},
        '{ROW_CFG, CFG_MODE, 12'(MODE_ONLY_OF_TYPE), NO_SIB, WANT_CALC},
        '{ROW_ITEM, CFG_MODE, 12'h000, '{KIND_EMPTY, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0},
          WANT_ONE},
        '{ROW_ITEM, CFG_MODE, 12'h000, '{KIND_NO_PARENT, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0},
          WANT_ZERO},
        '{ROW_CFG, CFG_MODE, 12'(MODE_BOGUS), NO_SIB, WANT_CALC},
        '{ROW_ITEM, CFG_MODE, 12'h000, '{KIND_EMPTY, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0},
          WANT_ZERO},
        '{ROW_CFG, CFG_MODE, 12'(MODE_ONLY), NO_SIB, WANT_CALC},
        '{ROW_ITEM, CFG_MODE, 12'h000, '{KIND_ENTRY, 16'h0001, 16'h0002, 1'b0, 1'b0, 1'b0},
          WANT_CALC},
        '{ROW_ITEM, CFG_MODE, 12'h000, '{KIND_ENTRY, 16'h0002, 16'h0002, 1'b1, 1'b1, 1'b1},
          WANT_ONE},
        '{ROW_CFG, CFG_MODE, 12'(MODE_FIRST_OF_TYPE), NO_SIB, WANT_CALC},
        '{ROW_ITEM, CFG_MODE, 12'h000, '{KIND_ENTRY, 16'h5555, 16'h5555, 1'b1, 1'b1, 1'b0},
          WANT_CALC},
        '{ROW_ITEM, CFG_MODE, 12'h000, '{KIND_NO_PARENT, 16'h5555, 16'h5555, 1'b1, 1'b0, 1'b0},
          WANT_ZERO},
        '{ROW_ITEM, CFG_MODE, 12'h000, '{KIND_ENTRY, 16'h5555, 16'h5555, 1'b1, 1'b0, 1'b1},
          WANT_ZERO},
        '{ROW_CFG, CFG_MODE, 12'(MODE_LAST), NO_SIB, WANT_CALC},
        '{ROW_ITEM, CFG_MODE, 12'h000, '{KIND_ENTRY, 16'hAAAA, 16'hAAAA, 1'b0, 1'b1, 1'b1},
          WANT_ONE},
        '{ROW_CFG, CFG_MODE, 12'(MODE_NTH_LAST), NO_SIB, WANT_CALC},
        '{ROW_CFG, CFG_COEF_A, 12'h000, NO_SIB, WANT_CALC},
        '{ROW_CFG, CFG_OFFSET_B, 12'h001, NO_SIB, WANT_CALC},
        '{ROW_ITEM, CFG_MODE, 12'h000, '{KIND_EMPTY, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0},
          WANT_CALC},
        '{ROW_CFG, CFG_MODE, 12'(MODE_NTH_OF_TYPE), NO_SIB, WANT_CALC},
        '{ROW_CFG, CFG_COEF_A, 12'h002, NO_SIB, WANT_CALC},
        '{ROW_CFG, CFG_OFFSET_B, 12'h000, NO_SIB, WANT_CALC},
        '{ROW_ITEM, CFG_MODE, 12'h000, '{KIND_ENTRY, 16'h7777, 16'h7777, 1'b1, 1'b0, 1'b0},
          WANT_CALC},
        '{ROW_ITEM, CFG_MODE, 12'h000, '{KIND_ENTRY, 16'h7777, 16'h7777, 1'b1, 1'b1, 1'b1},
          WANT_CALC}
    };

    // Shadow copy of the configuration registers.
    logic [MODE_W-1:0] sel_mode;
    int                step_a;
    int                ofs_b;

    // Shadow copy of the per-list counters.
    bit seen_tgt;
    bit first_tgt;
    bit saw_visible;
    int vis_pre;
    int vis_post;
    int tag_pre;
    int tag_post;
    int n_entries;

    bit pending_matches [$];   // match bits still owed by the block
    int mismatches;
    int sent;                  // counted sibling transactions (unknown kinds excluded)
    bit calm;                  // phase with no idling on either side
    bit want_bit;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Safety net: far beyond the slowest legal run.
    initial
    begin
        #2000000;
        $display("testbench: FAIL");
        $finish;
    end

    function automatic int bump(input int c);
        return (c < CNT_LIMIT) ? c + 1 : c;
    endfunction

    function automatic void clear_list();
        seen_tgt    = 1'b0;
        first_tgt   = 1'b0;
        saw_visible = 1'b0;
        vis_pre     = 0;
        vis_post    = 0;
        tag_pre     = 0;
        tag_post    = 0;
        n_entries   = 0;
    endfunction

    // an+b test against a 1-based position; division truncates towards zero.
    function automatic bit nth_hit(input int pos);
        int x;
        x = pos - ofs_b;
        if (step_a != 0)
            x = x / step_a;
        return (x >= 0) && (x * step_a + ofs_b == pos);
    endfunction

    function automatic bit classify(input bit last_tgt);
        case (sel_mode)
            MODE_EMPTY:            return !saw_visible;
            MODE_FIRST:            return first_tgt;
            MODE_FIRST_OF_TYPE:    return seen_tgt && tag_pre == 0;
            MODE_LAST:             return last_tgt;
            MODE_LAST_OF_TYPE:     return seen_tgt && tag_post == 0;
            MODE_NTH:              return nth_hit(1 + vis_pre);
            MODE_NTH_LAST:         return nth_hit(1 + (seen_tgt ? vis_post : vis_pre));
            MODE_NTH_LAST_OF_TYPE: return nth_hit(1 + (seen_tgt ? tag_post : tag_pre));
            MODE_NTH_OF_TYPE:      return nth_hit(1 + tag_pre);
            MODE_ONLY:             return vis_pre == 0 && vis_post == 0;
            MODE_ONLY_OF_TYPE:     return tag_pre == 0 && tag_post == 0;
            default:               return 1'b0;
        endcase
    endfunction

    // Advance the shadow list state by one accepted sibling transaction.
    function automatic void track_sibling(input sib_t it, output bit has, output bit val);
        bit now_tgt;
        has = 1'b0;
        val = 1'b0;
        if (it.kind == KIND_UNUSED)
            return;
        if (it.kind == KIND_NO_PARENT)
        begin
            clear_list();
            has = 1'b1;
            return;
        end
        if (it.kind == KIND_EMPTY)
        begin
            clear_list();
            has = 1'b1;
            val = classify(1'b0);
            return;
        end
        // only the first marked entry is the target; later ones are ordinary siblings
        now_tgt = it.is_target && !seen_tgt;
        if (n_entries == 0)
            first_tgt = now_tgt;
        if (it.visible)
            saw_visible = 1'b1;
        if (now_tgt)
            seen_tgt = 1'b1;
        else if (it.visible)
        begin
            if (seen_tgt)
            begin
                vis_post = bump(vis_post);
                if (it.tag_id == it.target_tag)
                    tag_post = bump(tag_post);
            end
            else
            begin
                vis_pre = bump(vis_pre);
                if (it.tag_id == it.target_tag)
                    tag_pre = bump(tag_pre);
            end
        end
        n_entries = bump(n_entries);
        if (it.last_item)
        begin
            has = 1'b1;
            val = classify(now_tgt);
            clear_list();
        end
    endfunction

    // Mostly back to back, sometimes a short gap, now and then a long one.
    function automatic int gap_len();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    // Offer one sibling transaction; call at a falling edge, returns at one.
    // Valid stays high on return unless a gap was taken.
    task automatic push_sib(input sib_t it, input want_t want);
        bit has;
        bit val;
        int g;
        sib_if.valid      <= 1'b1;
        sib_if.kind       <= it.kind;
        sib_if.tag_id     <= it.tag_id;
        sib_if.target_tag <= it.target_tag;
        sib_if.visible    <= it.visible;
        sib_if.is_target  <= it.is_target;
        sib_if.last_item  <= it.last_item;
        do
            @(posedge clk);
        while (!sib_if.ready);
        track_sibling(it, has, val);
        if (has)
            pending_matches.push_back(want == WANT_CALC ? val : (want == WANT_ONE));
        if (it.kind != KIND_UNUSED)
            sent++;
        @(negedge clk);
        g = gap_len();
        if (g > 0)
        begin
            sib_if.valid <= 1'b0;
            repeat (g) @(negedge clk);
        end
    endtask

    // Write one register once the block has gone quiet; call at a falling edge.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        sib_if.valid <= 1'b0;
        while (pending_matches.size() != 0)
            @(negedge clk);
        // let a closing transaction still in the divider settle
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        case (idx)
            CFG_MODE:     sel_mode = data[MODE_W-1:0];
            CFG_COEF_A:   step_a   = int'($signed(data));
            CFG_OFFSET_B: ofs_b    = int'($signed(data));
            default:      ;
        endcase
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    function automatic int pick_coef(input int lo, input int hi);
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return -1024;
        if (r < 20)
            return 1024;
        if (r < 30)
            return 0;
        if (r < 75)
            return $urandom_range(0, hi - lo) + lo;
        return $urandom_range(0, 2048) - 1024;
    endfunction

    function automatic sib_t rand_sib(input logic [KIND_W-1:0] kind);
        sib_t it;
        it.kind       = kind;
        it.tag_id     = 16'($urandom);
        it.target_tag = 16'($urandom);
        it.visible    = 1'($urandom_range(0, 1));
        it.is_target  = 1'($urandom_range(0, 1));
        it.last_item  = 1'($urandom_range(0, 1));
        return it;
    endfunction

    // One sibling list with random content: mostly well formed, sometimes cut short
    // by a no-parent or empty-list transaction, with unknown kinds sprinkled in.
    task automatic run_list();
        int          len;
        int          tpos;
        int          style;
        int          cut;
        int          r;
        int          i;
        logic [15:0] own_tag;
        logic [15:0] other_tag;
        sib_t        it;
        r = $urandom_range(0, 99);
        if (r < 8)
        begin
            push_sib(rand_sib($urandom_range(0, 1) ? KIND_NO_PARENT : KIND_EMPTY), WANT_CALC);
            return;
        end
        r = $urandom_range(0, 99);
        if (r < 70)
            len = $urandom_range(1, 6);
        else if (r < 90)
            len = $urandom_range(7, 14);
        else
            len = $urandom_range(20, 40);   // around and past the counter cap
        own_tag   = 16'($urandom);
        other_tag = 16'($urandom);
        style     = $urandom_range(0, 9);  // 0: no target, 1: several marked
        r = $urandom_range(0, 4);
        tpos = (r == 0) ? 0 : (r == 1) ? len - 1 : $urandom_range(0, len - 1);
        cut  = ($urandom_range(0, 19) == 0) ? $urandom_range(0, len - 1) : len;
        for (i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 24) == 0)
                push_sib(rand_sib(KIND_UNUSED), WANT_CALC);
            if (i == cut)
            begin
                push_sib(rand_sib($urandom_range(0, 1) ? KIND_NO_PARENT : KIND_EMPTY),
                         WANT_CALC);
                return;
            end
            it.kind       = KIND_ENTRY;
            it.is_target  = (style != 0 && i == tpos) ||
                            (style == 1 && $urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (it.is_target && r < 90)
                it.tag_id = own_tag;
            else if (r < 45)
                it.tag_id = own_tag;
            else if (r < 80)
                it.tag_id = other_tag;
            else
                it.tag_id = 16'($urandom);
            // the target tag is read per entry, so let it wander now and then
            it.target_tag = ($urandom_range(0, 29) == 0) ? 16'($urandom) : own_tag;
            it.visible    = ($urandom_range(0, 3) != 0);
            it.last_item  = (i == len - 1);
            push_sib(it, WANT_CALC);
        end
    endtask

    // Receiver: stall at random, with calm phases running flat out.
    initial
    begin : result_sink
        int hold;
        hold = 0;
        res_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                res_if.ready <= 1'b0;
                hold--;
            end
            else
            begin
                res_if.ready <= 1'b1;
                hold = gap_len();
            end
        end
    end

    // Compare every result transaction with the oldest owed match bit.
    always @(posedge clk)
    begin
        if (rst_n && res_if.valid && res_if.ready)
        begin
            if (pending_matches.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transaction: matched=%0b at %0t",
                             res_if.matched, $realtime);
            end
            else
            begin
                want_bit = pending_matches.pop_front();
                if (res_if.matched !== want_bit)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("matched mismatch: expected %0b, got %0b at %0t",
                                 want_bit, res_if.matched, $realtime);
                end
            end
        end
    end

    initial
    begin : stimulus
        int i;
        int n_lists;
        // hold every input at a known value from time zero
        rst_n             = 1'b0;
        sib_if.valid      = 1'b0;
        sib_if.kind       = KIND_ENTRY;
        sib_if.tag_id     = '0;
        sib_if.target_tag = '0;
        sib_if.visible    = 1'b0;
        sib_if.is_target  = 1'b0;
        sib_if.last_item  = 1'b0;
        cfg_if.valid      = 1'b0;
        cfg_if.index      = CFG_MODE;
        cfg_if.data       = '0;
        mismatches        = 0;
        sent              = 0;
        calm              = 1'b0;
        sel_mode          = MODE_EMPTY;
        step_a            = 0;
        ofs_b             = 1;
        clear_list();
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // walk the directed table
        for (i = 0; i < PLAN_LEN; i++)
        begin
            if (plan[i].act == ROW_CFG)
                write_reg(plan[i].idx, plan[i].data);
            else
                push_sib(plan[i].item, plan[i].want);
        end

        // random phases: fresh settings, then a batch of lists
        sent = 0;
        while (sent < RAND_ITEMS)
        begin
            calm = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 9) == 0)
                write_reg(MODE_W'(0) == 0 ? CFG_MODE : CFG_MODE,
                          12'($urandom_range(11, 15)));
            else
                write_reg(CFG_MODE, 12'($urandom_range(0, 10)));
            write_reg(CFG_COEF_A, 12'(pick_coef(-4, 4)));
            write_reg(CFG_OFFSET_B, 12'(pick_coef(-3, 6)));
            if ($urandom_range(0, 9) == 0)
                write_reg(CFG_UNUSED, 12'($urandom));   // no such register: ignored
            n_lists = $urandom_range(6, 20);
            repeat (n_lists) run_list();
        end

        // drain: wait for every owed result, then watch for strays
        sib_if.valid <= 1'b0;
        while (pending_matches.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_matches.size() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
